/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, sampled on clk_i, off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/lltr_pkg.sv */
// ----------------------------------------------------------------------------
// lltr_pkg
// Types, widths and constants shared by the LMS neuron trainer modules.
// ----------------------------------------------------------------------------
package lltr_pkg;

  localparam int SMP_W  = 16;  // Q2.14 samples and target
  localparam int Q_W    = 32;  // Q8.24 weights, bias, estimate
  localparam int LR_W   = 16;  // Q0.16 step size
  localparam int OPA_W  = 34;  // weight, error or step operand
  localparam int OPB_W  = 17;  // sample or step size operand
  localparam int PROD_W = OPA_W + OPB_W;
  localparam int ACC_W  = 52;
  localparam int SUM_W  = 39;  // pre-saturation width
  localparam int CFG_IDX_W = 8;
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 40;

  localparam logic signed [Q_W-1:0] WEIGHT_RESET = 32'sd8388608;
  localparam logic [LR_W-1:0]       LR_RESET     = 16'd655;
  localparam logic signed [Q_W-1:0] THR_RESET    = 32'sd8388608;

  localparam logic [CFG_IDX_W-1:0] CFG_LEARNING_RATE      = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DECISION_THRESHOLD = 8'd1;

  typedef enum logic [2:0] {
    MSEL_WA, MSEL_WB, MSEL_WC, MSEL_LR, MSEL_SA, MSEL_SB, MSEL_SC
  } mul_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MA, ST_MB, ST_MC, ST_SUM, ST_EST, ST_ERR, ST_STEP,
    ST_WA, ST_WB, ST_WC, ST_WO, ST_DONE
  } seq_state_e;

  typedef struct packed {
    logic     acc_init;
    logic     acc_add;
    logic     est_load;
    logic     step_load;
    logic     upd_a;
    logic     upd_b;
    logic     upd_c;
    logic     upd_off;
    logic     out_load;
    logic     mul_en;
    mul_sel_e mul_sel;
  } ctrl_t;

  function automatic logic signed [Q_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'(signed'(32'h7fff_ffff));
    lo = -SUM_W'(signed'(33'h0_8000_0000));
    if (v > hi) begin
      return 32'sh7fff_ffff;
    end else if (v < lo) begin
      return 32'sh8000_0000;
    end
    return v[Q_W-1:0];
  endfunction

endpackage

/* sv/lltr_mul.sv */
// ----------------------------------------------------------------------------
// lltr_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module lltr_mul (
  input  logic                                   clk_i,
  input  logic                                   en_i,
  input  logic signed [lltr_pkg::OPA_W-1:0]      op_a_i,
  input  logic signed [lltr_pkg::OPB_W-1:0]      op_b_i,
  output logic signed [lltr_pkg::PROD_W-1:0]     prod_o
);
  import lltr_pkg::*;

  logic signed [PROD_W-1:0] prod_q;
  logic signed [PROD_W-1:0] prod_d;

  assign prod_d = PROD_W'(op_a_i) * PROD_W'(op_b_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

/* sv/lltr_seq.sv */
// ----------------------------------------------------------------------------
// lltr_seq
// Sequencer: steps the shared multiplier through prediction and update.
// ----------------------------------------------------------------------------
module lltr_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            train_i,
  input  logic            out_free_i,
  output logic            in_ready_o,
  output lltr_pkg::ctrl_t ctrl_o
);
  import lltr_pkg::*;

  seq_state_e state_q;
  seq_state_e state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    ctrl_o     = '0;
    ctrl_o.mul_sel = MSEL_WA;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.acc_init = 1'b1;
          state_d = ST_MA;
        end
      end
      ST_MA: begin
        ctrl_o.mul_en  = 1'b1;
        ctrl_o.mul_sel = MSEL_WA;
        state_d = ST_MB;
      end
      ST_MB: begin
        ctrl_o.mul_en  = 1'b1;
        ctrl_o.mul_sel = MSEL_WB;
        ctrl_o.acc_add = 1'b1;
        state_d = ST_MC;
      end
      ST_MC: begin
        ctrl_o.mul_en  = 1'b1;
        ctrl_o.mul_sel = MSEL_WC;
        ctrl_o.acc_add = 1'b1;
        state_d = ST_SUM;
      end
      ST_SUM: begin
        ctrl_o.acc_add = 1'b1;
        state_d = ST_EST;
      end
      ST_EST: begin
        ctrl_o.est_load = 1'b1;
        state_d = train_i ? ST_ERR : ST_DONE;
      end
      ST_ERR: begin
        ctrl_o.mul_en  = 1'b1;
        ctrl_o.mul_sel = MSEL_LR;
        state_d = ST_STEP;
      end
      ST_STEP: begin
        ctrl_o.step_load = 1'b1;
        state_d = ST_WA;
      end
      ST_WA: begin
        ctrl_o.mul_en  = 1'b1;
        ctrl_o.mul_sel = MSEL_SA;
        state_d = ST_WB;
      end
      ST_WB: begin
        ctrl_o.mul_en  = 1'b1;
        ctrl_o.mul_sel = MSEL_SB;
        ctrl_o.upd_a   = 1'b1;
        state_d = ST_WC;
      end
      ST_WC: begin
        ctrl_o.mul_en  = 1'b1;
        ctrl_o.mul_sel = MSEL_SC;
        ctrl_o.upd_b   = 1'b1;
        state_d = ST_WO;
      end
      ST_WO: begin
        ctrl_o.upd_c   = 1'b1;
        ctrl_o.upd_off = 1'b1;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        // hold until the output register can take the result
        if (out_free_i) begin
          ctrl_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

/* sv/lms_linear_neuron_trainer.sv */
// Predict-only work runs the three products, the sum and the estimate; train mode
// adds the step and the three weight updates, plus any wait for the output register to drain.
// A request is taken only in idle, after the last result went to the output register; the single
// shared multiplier is used for three products, the step and three weight deltas.
// Reset: weights and bias to 0.5, step size 655, decision_threshold 0.5.
// ----------------------------------------------------------------------------
// lms_linear_neuron_trainer
// Three-input linear neuron trained online by the LMS delta rule (Q8.24).
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lms_linear_neuron_trainer (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // config write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [lltr_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [31:0]                         cfg_data_i,
  // input stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata: sample_a[15:0], sample_b[31:16], sample_c[47:32], desired[63:48]
  input  logic [lltr_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // tuser: mode[0]
  input  logic                                s_axis_tuser,
  // output stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // tdata: estimate[31:0], decision[32], zero[39:33]
  output logic [lltr_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);
  import lltr_pkg::*;

  ctrl_t ctrl;
  logic  in_ready;
  logic  in_acc;
  logic  out_free;

  logic [LR_W-1:0]       lr_q;
  logic signed [Q_W-1:0] thr_q;

  logic signed [Q_W-1:0] w_a_q, w_b_q, w_c_q, offset_q;

  logic                    mode_q;
  logic signed [SMP_W-1:0] xa_q, xb_q, xc_q, target_q;

  logic signed [ACC_W-1:0]  acc_q;
  logic signed [Q_W-1:0]    est_q;
  logic signed [OPA_W-1:0]  step_q;
  logic signed [PROD_W-1:0] prod;

  logic signed [OPA_W-1:0] op_a;
  logic signed [OPB_W-1:0] op_b;
  logic signed [OPA_W-1:0] err;

  logic signed [ACC_W:0]    acc_rnd;
  logic signed [Q_W-1:0]    est_d;
  logic signed [ACC_W-1:0]  prod_rnd16;
  logic signed [ACC_W-1:0]  prod_rnd14;
  logic signed [OPA_W-1:0]  step_d;
  logic signed [ACC_W-15:0] delta;
  logic signed [Q_W-1:0]    w_upd_src;
  logic signed [Q_W-1:0]    w_new;
  logic signed [Q_W-1:0]    off_new;

  logic                    out_valid_q;
  logic signed [Q_W-1:0]   out_est_q;
  logic                    out_dec_q;

  assign in_acc   = s_axis_tvalid && in_ready;
  assign out_free = !out_valid_q || m_axis_tready;

  lltr_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .train_i    (!mode_q),
    .out_free_i (out_free),
    .in_ready_o (in_ready),
    .ctrl_o     (ctrl)
  );

  // error = desired * 2^10 - estimate
  assign err = (OPA_W'(target_q) <<< 10) - OPA_W'(est_q);

  always_comb begin
    case (ctrl.mul_sel)
      MSEL_WA: begin op_a = OPA_W'(w_a_q); op_b = OPB_W'(xa_q); end
      MSEL_WB: begin op_a = OPA_W'(w_b_q); op_b = OPB_W'(xb_q); end
      MSEL_WC: begin op_a = OPA_W'(w_c_q); op_b = OPB_W'(xc_q); end
      MSEL_LR: begin op_a = err;           op_b = signed'({1'b0, lr_q}); end
      MSEL_SA: begin op_a = step_q;        op_b = OPB_W'(xa_q); end
      MSEL_SB: begin op_a = step_q;        op_b = OPB_W'(xb_q); end
      MSEL_SC: begin op_a = step_q;        op_b = OPB_W'(xc_q); end
      default: begin op_a = '0;            op_b = '0; end
    endcase
  end

  lltr_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (ctrl.mul_en),
    .op_a_i (op_a),
    .op_b_i (op_b),
    .prod_o (prod)
  );

  // rounding shifts, half up
  assign acc_rnd    = (ACC_W+1)'(acc_q) + (ACC_W+1)'(8192);
  assign est_d      = sat32(acc_rnd[ACC_W:14]);
  assign prod_rnd16 = ACC_W'(prod) + ACC_W'(32768);
  assign step_d     = prod_rnd16[49:16];
  assign prod_rnd14 = ACC_W'(prod) + ACC_W'(8192);
  assign delta      = prod_rnd14[ACC_W-1:14];

  always_comb begin
    case (1'b1)
      ctrl.upd_a: w_upd_src = w_a_q;
      ctrl.upd_b: w_upd_src = w_b_q;
      default:    w_upd_src = w_c_q;
    endcase
  end

  assign w_new   = sat32(SUM_W'(w_upd_src) + SUM_W'(delta));
  assign off_new = sat32(SUM_W'(offset_q) + SUM_W'(step_q));

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lr_q  <= LR_RESET;
      thr_q <= THR_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_LEARNING_RATE:      lr_q  <= cfg_data_i[LR_W-1:0];
        CFG_DECISION_THRESHOLD: thr_q <= signed'(cfg_data_i);
        default: ;
      endcase
    end
  end

  // learned state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_a_q    <= WEIGHT_RESET;
      w_b_q    <= WEIGHT_RESET;
      w_c_q    <= WEIGHT_RESET;
      offset_q <= WEIGHT_RESET;
    end else begin
      if (ctrl.upd_a)   w_a_q    <= w_new;
      if (ctrl.upd_b)   w_b_q    <= w_new;
      if (ctrl.upd_c)   w_c_q    <= w_new;
      if (ctrl.upd_off) offset_q <= off_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b1;
    end else if (in_acc) begin
      mode_q <= s_axis_tuser;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      xa_q     <= signed'(s_axis_tdata[15:0]);
      xb_q     <= signed'(s_axis_tdata[31:16]);
      xc_q     <= signed'(s_axis_tdata[47:32]);
      target_q <= signed'(s_axis_tdata[63:48]);
    end
    if (ctrl.acc_init) begin
      acc_q <= ACC_W'(offset_q) <<< 14;
    end else if (ctrl.acc_add) begin
      acc_q <= acc_q + ACC_W'(prod);
    end
    if (ctrl.est_load)  est_q  <= est_d;
    if (ctrl.step_load) step_q <= step_d;
    if (ctrl.out_load) begin
      out_est_q <= est_q;
      out_dec_q <= (est_q > thr_q);
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign s_axis_tready = in_ready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_dec_q, out_est_q};

  // an accepted request keeps the input closed for the next cycle
  `ASSERT_NEXT(a_busy_after_req, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input reopened")
  // predict-only work leaves the learned state alone
  `ASSERT_NEXT(a_infer_w, !s_axis_tready && mode_q, $stable(w_a_q), "weight moved in predict")
  `ASSERT_NEXT(a_infer_off, !s_axis_tready && mode_q, $stable(offset_q), "bias moved in predict")
  // a result is never loaded over one that is still waiting
  `ASSERT_IMPL(a_no_overwrite, ctrl.out_load, !out_valid_q || m_axis_tready, "overwrite")

endmodule

/* sim/lms_trainer_checker.sv */
// ----------------------------------------------------------------------------
// lms_trainer_checker
// Watches the config, request and result channels of the LMS neuron trainer,
// keeps its own copy of weights, bias and registers, predicts each result and
// compares it with what the block returns, in order.
// ----------------------------------------------------------------------------
module lms_trainer_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  input  logic                                cfg_ready_i,
  input  logic [lltr_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [31:0]                         cfg_data_i,
  input  logic                                req_valid_i,
  input  logic                                req_ready_i,
  // req_data_i: sample_a[15:0], sample_b[31:16], sample_c[47:32], desired[63:48]
  input  logic [lltr_pkg::IN_DATA_W-1:0]      req_data_i,
  // req_user_i: mode[0]
  input  logic                                req_user_i,
  input  logic                                res_valid_i,
  input  logic                                res_ready_i,
  // res_data_i: estimate[31:0], decision[32], zero[39:33]
  input  logic [lltr_pkg::OUT_DATA_W-1:0]     res_data_i,
  output int                                  error_count_o,
  output int                                  pending_o
);

  timeunit 1ns;
  timeprecision 1ps;

  import lltr_pkg::*;

  localparam longint Q_HI = 64'sd2147483647;
  localparam longint Q_LO = -64'sd2147483648;

  typedef struct packed {
    logic signed [Q_W-1:0] estimate;
    logic                  decision;
  } neuron_out_t;

  neuron_out_t expected_outputs[$];

  longint step_size;
  longint threshold;
  longint weight_a;
  longint weight_b;
  longint weight_c;
  longint bias;

  // floor((v + 2^(s-1)) / 2^s)
  function automatic longint round_shift(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp_q(longint v);
    if (v > Q_HI) return Q_HI;
    if (v < Q_LO) return Q_LO;
    return v;
  endfunction

  // predicts one result and applies the delta-rule update in train mode
  task automatic predict_and_learn(input logic mode, input logic [IN_DATA_W-1:0] data);
    logic signed [SMP_W-1:0] sa;
    logic signed [SMP_W-1:0] sb;
    logic signed [SMP_W-1:0] sc;
    logic signed [SMP_W-1:0] sd;
    longint xa;
    longint xb;
    longint xc;
    longint target;
    longint acc;
    longint est;
    longint err;
    longint delta;
    neuron_out_t res;
    sa = data[15:0];
    sb = data[31:16];
    sc = data[47:32];
    sd = data[63:48];
    xa = sa;
    xb = sb;
    xc = sc;
    target = sd;
    acc = weight_a * xa + weight_b * xb + weight_c * xc + bias * 16384;
    est = clamp_q(round_shift(acc, 14));
    if (!mode) begin
      err = target * 1024 - est;
      delta = round_shift(step_size * err, 16);
      weight_a = clamp_q(weight_a + round_shift(delta * xa, 14));
      weight_b = clamp_q(weight_b + round_shift(delta * xb, 14));
      weight_c = clamp_q(weight_c + round_shift(delta * xc, 14));
      bias     = clamp_q(bias + delta);
    end
    res.estimate = est[Q_W-1:0];
    res.decision = (est > threshold);
    expected_outputs.push_back(res);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    neuron_out_t exp_out;
    logic signed [Q_W-1:0] got_est;
    if (!rst_ni) begin
      step_size = LR_RESET;
      threshold = THR_RESET;
      weight_a = WEIGHT_RESET;
      weight_b = WEIGHT_RESET;
      weight_c = WEIGHT_RESET;
      bias = WEIGHT_RESET;
      expected_outputs.delete();
      error_count_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        // unknown indexes are dropped by the block
        if (cfg_index_i == CFG_LEARNING_RATE) begin
          step_size = cfg_data_i[LR_W-1:0];
        end else if (cfg_index_i == CFG_DECISION_THRESHOLD) begin
          threshold = signed'(cfg_data_i);
        end
      end
      if (req_valid_i && req_ready_i) begin
        predict_and_learn(req_user_i, req_data_i);
      end
      if (res_valid_i && res_ready_i) begin
        if (expected_outputs.size() == 0) begin
          $error("unexpected result, tdata %h", res_data_i);
          error_count_o++;
        end else begin
          exp_out = expected_outputs.pop_front();
          got_est = res_data_i[31:0];
          if (got_est !== exp_out.estimate) begin
            $error("estimate: expected %0d, got %0d", exp_out.estimate, got_est);
            error_count_o++;
          end
          if (res_data_i[32] !== exp_out.decision) begin
            $error("decision: expected %0d, got %0d", exp_out.decision, res_data_i[32]);
            error_count_o++;
          end
          if (res_data_i[39:33] !== 7'd0) begin
            $error("pad: expected %0d, got %0d", 7'd0, res_data_i[39:33]);
            error_count_o++;
          end
        end
      end
    end
    pending_o = expected_outputs.size();
  end

endmodule

/* sim/tb_lms_linear_neuron_trainer.sv */
// ----------------------------------------------------------------------------
// tb_lms_linear_neuron_trainer
// Drives the LMS neuron trainer with directed extremes, then with trained and
// random requests under changing step size, threshold and back-pressure.
// ----------------------------------------------------------------------------
module tb_lms_linear_neuron_trainer;

  timeunit 1ns;
  timeprecision 1ps;

  import lltr_pkg::*;

  localparam int IDLE_LIMIT = 4000;
  localparam int LONG_STALL = 500;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 8'd2;

  typedef struct packed {
    logic signed [SMP_W-1:0] desired;
    logic signed [SMP_W-1:0] sample_c;
    logic signed [SMP_W-1:0] sample_b;
    logic signed [SMP_W-1:0] sample_a;
  } neuron_req_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i = '0;
  logic [31:0]            cfg_data_i = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
  logic                   s_axis_tuser = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  m_axis_tdata;

  int  check_errors;
  int  check_pending;
  int  send_idle_pct = 35;
  int  recv_idle_pct = 66;
  logic long_stall_req = 1'b0;
  int  teach_a;
  int  teach_b;
  int  teach_c;
  int  teach_bias;

  lms_linear_neuron_trainer DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  lms_trainer_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .req_valid_i   (s_axis_tvalid),
    .req_ready_i   (s_axis_tready),
    .req_data_i    (s_axis_tdata),
    .req_user_i    (s_axis_tuser),
    .res_valid_i   (m_axis_tvalid),
    .res_ready_i   (m_axis_tready),
    .res_data_i    (m_axis_tdata),
    .error_count_o (check_errors),
    .pending_o     (check_pending)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // result side: random idling, plus one long hold-off on request
  initial begin
    int  stall_left;
    logic stall_seen;
    stall_left = 0;
    stall_seen = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_stall_req && !stall_seen) begin
        stall_left = LONG_STALL;
      end
      stall_seen = long_stall_req;
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // ends the run when no channel moves for too long
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_lms_linear_neuron_trainer: errors");
        $finish;
      end
    end
  end

  // called at a falling edge, returns at a falling edge; valid stays up
  task automatic send_request(input logic mode, input logic [15:0] a, input logic [15:0] b,
                              input logic [15:0] c, input logic [15:0] d);
    neuron_req_t req;
    req.sample_a = a;
    req.sample_b = b;
    req.sample_c = c;
    req.desired  = d;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= {$urandom, $urandom};
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= req;
    s_axis_tuser  <= mode;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
  endtask

  // every request yields a result, the extra cycles only cover the tail
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (check_pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic set_registers(input logic [15:0] lr, input logic [31:0] thr);
    wait_drained();
    cfg_write(CFG_LEARNING_RATE, {16'($urandom_range(65535)), lr});
    if ($urandom_range(1)) begin
      cfg_write(CFG_UNUSED + CFG_IDX_W'($urandom_range(253)), $urandom);
    end
    cfg_write(CFG_DECISION_THRESHOLD, thr);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [15:0] clip16(int v);
    if (v > 32767) return 16'h7fff;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  // mostly targets from a fixed linear teacher so the weights converge
  task automatic run_random(input int count);
    int sa;
    int sb;
    int sc;
    int pick;
    teach_a = int'($urandom_range(32767)) - 16384;
    teach_b = int'($urandom_range(32767)) - 16384;
    teach_c = int'($urandom_range(32767)) - 16384;
    teach_bias = int'($urandom_range(16383)) - 8192;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        sa = int'($urandom_range(16383)) - 8192;
        sb = int'($urandom_range(16383)) - 8192;
        sc = int'($urandom_range(16383)) - 8192;
        send_request(1'b0, sa[15:0], sb[15:0], sc[15:0],
                     clip16(((teach_a * sa + teach_b * sb + teach_c * sc) >>> 14) +
                            teach_bias));
      end else if (pick < 70) begin
        sa = int'($urandom_range(16383)) - 8192;
        sb = int'($urandom_range(16383)) - 8192;
        sc = int'($urandom_range(16383)) - 8192;
        send_request(1'b1, sa[15:0], sb[15:0], sc[15:0], 16'($urandom_range(65535)));
      end else begin
        send_request(1'($urandom_range(1)), 16'($urandom_range(65535)),
                     16'($urandom_range(65535)), 16'($urandom_range(65535)),
                     16'($urandom_range(65535)));
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings; first request hits estimate equal to threshold
    send_request(1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_request(1'b1, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_request(1'b1, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_request(1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_request(1'b0, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_request(1'b0, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_request(1'b0, 16'h7fff, 16'h8000, 16'h0001, 16'h8000);
    send_request(1'b0, 16'hffff, 16'h0001, 16'h7fff, 16'h7fff);
    send_request(1'b1, 16'h4000, 16'h4000, 16'h4000, 16'h0000);

    // full step size drives weights and estimate into saturation
    set_registers(16'hffff, 32'h7fff_ffff);
    send_request(1'b0, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_request(1'b0, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_request(1'b1, 16'h7fff, 16'h7fff, 16'h7fff, 16'h0000);
    send_request(1'b1, 16'h8000, 16'h8000, 16'h8000, 16'h0000);
    send_request(1'b0, 16'h8000, 16'h8000, 16'h8000, 16'h7fff);
    send_request(1'b0, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000);
    send_request(1'b0, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_request(1'b1, 16'h7fff, 16'h8000, 16'h7fff, 16'h0000);

    set_registers(16'd655, 32'h8000_0000);
    run_random(600);

    send_idle_pct = 66;
    recv_idle_pct = 35;
    set_registers(16'd0, $urandom);
    run_random(300);
    set_registers(16'($urandom_range(65535)),
                  32'(int'($urandom_range(33554431)) - 16777216));
    run_random(300);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_registers(16'($urandom_range(4000, 1)), 32'h0000_0000);
    run_random(400);
    long_stall_req <= 1'b1;
    run_random(400);

    wait_drained();
    if (check_errors == 0 && check_pending == 0) begin
      $display("tb_lms_linear_neuron_trainer: clean");
    end else begin
      $display("tb_lms_linear_neuron_trainer: errors");
    end
    $finish;
  end

endmodule
